// ----- hdl/hcb_pkg.sv -----
// Shared types, codes and constants of the Huffman code builder.
package hcb_pkg;

    localparam int MAX_SYMBOLS_DEF = 64;
    localparam int FREQ_WIDTH_DEF  = 16;

    localparam int KIND_W   = 2;
    localparam int SYM_W    = 8;
    localparam int FREQ_IN_W = 16;
    localparam int STATUS_W = 2;
    localparam int CODE_W   = 63;
    localparam int LEN_W    = 6;
    localparam int COUNT_W  = 7;

    localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BUILD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd3;

    typedef struct packed {
        logic [KIND_W-1:0]    kind;
        logic [SYM_W-1:0]     symbol;
        logic [FREQ_IN_W-1:0] frequency;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [CODE_W-1:0]   code_bits;
        logic [LEN_W-1:0]    code_length;
        logic [COUNT_W-1:0]  symbol_count;
    } rsp_t;

    // controller -> datapath
    typedef struct packed {
        logic                accept;
        logic                scan_start;
        logic                scan_run;
        logic                scan_min;
        logic                load_wr;
        logic                clear;
        logic                build_init;
        logic                merge;
        logic                root_init;
        logic                walk_c0;
        logic                walk_c1;
        logic                q_sel;
        logic                q_cap;
        logic                set_ready;
        logic                fin;
        logic [STATUS_W-1:0] status;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;
        logic found;
        logic full;
        logic cnt_zero;
        logic lone;
        logic merge_last;
        logic walk_last;
        logic ready;
        logic rsp_free;
    } stat_t;

endpackage

// ----- hdl/hcb_ram.sv -----
// Generic simple dual-port RAM with registered read.
module hcb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/hcb_ctrl.sv -----
// Sequencer of the Huffman code builder: load, query, build and clear flows.
module hcb_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        req_valid,
    input  logic [hcb_pkg::KIND_W-1:0]  req_kind,
    output logic                        req_stall,
    output hcb_pkg::cmd_t               cmd,
    input  hcb_pkg::stat_t              stat
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FIND   = 4'd1;
    localparam logic [3:0] S_LOADWR = 4'd2;
    localparam logic [3:0] S_QRD    = 4'd3;
    localparam logic [3:0] S_QWAIT  = 4'd4;
    localparam logic [3:0] S_BINIT  = 4'd5;
    localparam logic [3:0] S_MSCAN  = 4'd6;
    localparam logic [3:0] S_MERGE  = 4'd7;
    localparam logic [3:0] S_RINIT  = 4'd8;
    localparam logic [3:0] S_WRD    = 4'd9;
    localparam logic [3:0] S_WC0    = 4'd10;
    localparam logic [3:0] S_WC1    = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    logic [3:0]                      state_reg, state_next;
    logic [hcb_pkg::KIND_W-1:0]      kind_reg, kind_next;
    logic [hcb_pkg::STATUS_W-1:0]    status_reg, status_next;

    assign req_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        kind_next   = kind_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.accept  = 1'b1;
                    kind_next   = req_kind;
                    status_next = hcb_pkg::ST_OK;
                    case (req_kind)
                        hcb_pkg::KIND_LOAD, hcb_pkg::KIND_QUERY:
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_FIND;
                        end
                        hcb_pkg::KIND_BUILD:
                        begin
                            if (stat.cnt_zero)
                            begin
                                status_next = hcb_pkg::ST_EMPTY;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_BINIT;
                            end
                        end
                        default:
                        begin
                            cmd.clear  = 1'b1;
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_FIND:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_done)
                begin
                    if (kind_reg == hcb_pkg::KIND_LOAD)
                    begin
                        state_next = S_LOADWR;
                    end
                    else if (stat.ready && stat.found)
                    begin
                        state_next = S_QRD;
                    end
                    else
                    begin
                        status_next = hcb_pkg::ST_ABSENT;
                        state_next  = S_DONE;
                    end
                end
            end
            S_LOADWR:
            begin
                cmd.load_wr = 1'b1;
                if (!stat.found && stat.full)
                begin
                    status_next = hcb_pkg::ST_FULL;
                end
                state_next = S_DONE;
            end
            S_QRD:
            begin
                cmd.q_sel  = 1'b1;
                state_next = S_QWAIT;
            end
            S_QWAIT:
            begin
                cmd.q_sel  = 1'b1;
                cmd.q_cap  = 1'b1;
                state_next = S_DONE;
            end
            S_BINIT:
            begin
                cmd.build_init = 1'b1;
                if (stat.lone)
                begin
                    state_next = S_RINIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_MSCAN;
                end
            end
            S_MSCAN:
            begin
                cmd.scan_run = 1'b1;
                cmd.scan_min = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = S_MERGE;
                end
            end
            S_MERGE:
            begin
                cmd.merge = 1'b1;
                if (stat.merge_last)
                begin
                    state_next = S_RINIT;
                end
                else
                begin
                    cmd.scan_start = 1'b1;
                    state_next     = S_MSCAN;
                end
            end
            S_RINIT:
            begin
                cmd.root_init = 1'b1;
                if (stat.lone)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_WRD:
            begin
                state_next = S_WC0;
            end
            S_WC0:
            begin
                cmd.walk_c0 = 1'b1;
                state_next  = S_WC1;
            end
            S_WC1:
            begin
                cmd.walk_c1 = 1'b1;
                if (stat.walk_last)
                begin
                    cmd.set_ready = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    state_next = S_WRD;
                end
            end
            S_DONE:
            begin
                if (stat.rsp_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            kind_reg   <= hcb_pkg::KIND_LOAD;
            status_reg <= hcb_pkg::ST_OK;
        end
        else
        begin
            state_reg  <= state_next;
            kind_reg   <= kind_next;
            status_reg <= status_next;
        end
    end

endmodule

// ----- hdl/hcb_dpath.sv -----
// Datapath: symbol/weight/tree/code memories, scan unit, merge and code walk.
module hcb_dpath #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int FREQ_WIDTH  = hcb_pkg::FREQ_WIDTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  hcb_pkg::req_t  req,
    input  hcb_pkg::cmd_t  cmd,
    output hcb_pkg::stat_t stat,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output hcb_pkg::rsp_t  rsp
);

    localparam int NSLOT = 2 * MAX_SYMBOLS - 1;
    localparam int NW    = $clog2(NSLOT);
    localparam int LW    = $clog2(MAX_SYMBOLS);
    localparam int CW    = $clog2(MAX_SYMBOLS + 1);
    localparam int WW    = FREQ_WIDTH + $clog2(MAX_SYMBOLS);
    localparam int PW    = hcb_pkg::CODE_W + hcb_pkg::LEN_W;

    // control state
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             ready_reg, ready_next;
    logic [NSLOT-1:0] active_reg, active_next;
    logic [NW-1:0]    scan_idx_reg, scan_idx_next;
    logic             pend_reg, pend_next;
    logic             found_reg, found_next;
    logic             best_ok_reg, best_ok_next;
    logic             sec_ok_reg, sec_ok_next;
    logic [NW-1:0]    next_reg, next_next;
    logic [NW-1:0]    p_reg, p_next;
    logic             rsp_valid_reg, rsp_valid_next;

    // payload
    logic [hcb_pkg::SYM_W-1:0]  sym_reg, sym_next;
    logic [FREQ_WIDTH-1:0]      freq_reg, freq_next;
    logic [NW-1:0]              rd_idx_reg, rd_idx_next;
    logic [LW-1:0]              fidx_reg, fidx_next;
    logic [WW-1:0]              best_w_reg, best_w_next;
    logic [NW-1:0]              best_i_reg, best_i_next;
    logic [WW-1:0]              sec_w_reg, sec_w_next;
    logic [NW-1:0]              sec_i_reg, sec_i_next;
    logic [hcb_pkg::CODE_W-1:0] qbits_reg, qbits_next;
    logic [hcb_pkg::LEN_W-1:0]  qlen_reg, qlen_next;
    hcb_pkg::rsp_t              rsp_reg, rsp_next;

    // memory ports
    logic                      leaf_we;
    logic [hcb_pkg::SYM_W-1:0] leaf_rdata;
    logic                      wt_we;
    logic [NW-1:0]             wt_waddr;
    logic [WW-1:0]             wt_wdata, wt_rdata;
    logic                      ch_we;
    logic [2*NW-1:0]           ch_rdata;
    logic                      path_we;
    logic [NW-1:0]             path_waddr, path_raddr;
    logic [PW-1:0]             path_wdata, path_rdata;

    logic [NW-1:0]             limit;
    logic [NW-1:0]             c0, c1;
    logic [hcb_pkg::CODE_W-1:0] base;
    logic [hcb_pkg::LEN_W-1:0]  dep;

    assign limit = cmd.scan_min ? next_reg : NW'(cnt_reg);
    assign c0    = ch_rdata[NW-1:0];
    assign c1    = ch_rdata[2*NW-1:NW];
    assign base  = {path_rdata[PW-2:hcb_pkg::LEN_W], 1'b0};
    assign dep   = path_rdata[hcb_pkg::LEN_W-1:0] + hcb_pkg::LEN_W'(1);

    assign leaf_we  = cmd.load_wr && !found_reg && (cnt_reg != CW'(MAX_SYMBOLS));
    assign wt_we    = cmd.merge || (cmd.load_wr && (found_reg || leaf_we));
    assign wt_waddr = cmd.merge ? next_reg : (found_reg ? NW'(fidx_reg) : NW'(cnt_reg));
    assign wt_wdata = cmd.merge ? WW'(best_w_reg + sec_w_reg) : WW'(freq_reg);
    assign ch_we    = cmd.merge;

    assign path_raddr = cmd.q_sel ? NW'(fidx_reg) : p_reg;

    always_comb
    begin
        path_we    = 1'b0;
        path_waddr = c0;
        path_wdata = {base, dep};
        if (cmd.root_init)
        begin
            path_we    = 1'b1;
            path_waddr = next_reg - NW'(1);
            path_wdata = '0;
        end
        else if (cmd.walk_c0)
        begin
            path_we = 1'b1;
        end
        else if (cmd.walk_c1)
        begin
            path_we    = 1'b1;
            path_waddr = c1;
            path_wdata = {base | hcb_pkg::CODE_W'(1), dep};
        end
    end

    hcb_ram #(.WIDTH(hcb_pkg::SYM_W), .DEPTH(MAX_SYMBOLS)) u_leaf (
        .clk   (clk),
        .we    (leaf_we),
        .waddr (cnt_reg[LW-1:0]),
        .wdata (sym_reg),
        .raddr (scan_idx_reg[LW-1:0]),
        .rdata (leaf_rdata)
    );

    hcb_ram #(.WIDTH(WW), .DEPTH(NSLOT)) u_weight (
        .clk   (clk),
        .we    (wt_we),
        .waddr (wt_waddr),
        .wdata (wt_wdata),
        .raddr (scan_idx_reg),
        .rdata (wt_rdata)
    );

    hcb_ram #(.WIDTH(2 * NW), .DEPTH(NSLOT)) u_child (
        .clk   (clk),
        .we    (ch_we),
        .waddr (next_reg),
        .wdata ({sec_i_reg, best_i_reg}),
        .raddr (p_reg),
        .rdata (ch_rdata)
    );

    // path memory doubles as the code/length table for leaves
    hcb_ram #(.WIDTH(PW), .DEPTH(NSLOT)) u_path (
        .clk   (clk),
        .we    (path_we),
        .waddr (path_waddr),
        .wdata (path_wdata),
        .raddr (path_raddr),
        .rdata (path_rdata)
    );

    always_comb
    begin
        cnt_next       = cnt_reg;
        ready_next     = ready_reg;
        active_next    = active_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = pend_reg;
        found_next     = found_reg;
        best_ok_next   = best_ok_reg;
        sec_ok_next    = sec_ok_reg;
        next_next      = next_reg;
        p_next         = p_reg;
        rsp_valid_next = rsp_valid_reg;
        sym_next       = sym_reg;
        freq_next      = freq_reg;
        rd_idx_next    = rd_idx_reg;
        fidx_next      = fidx_reg;
        best_w_next    = best_w_reg;
        best_i_next    = best_i_reg;
        sec_w_next     = sec_w_reg;
        sec_i_next     = sec_i_reg;
        qbits_next     = qbits_reg;
        qlen_next      = qlen_reg;
        rsp_next       = rsp_reg;

        if (cmd.accept)
        begin
            sym_next   = req.symbol;
            freq_next  = FREQ_WIDTH'(req.frequency);
            qbits_next = '0;
            qlen_next  = '0;
        end

        if (cmd.clear)
        begin
            cnt_next    = '0;
            ready_next  = 1'b0;
            active_next = '0;
        end

        // scan unit: one address per cycle, data compared in the following cycle
        if (cmd.scan_start)
        begin
            scan_idx_next = '0;
            pend_next     = 1'b0;
            found_next    = 1'b0;
            best_ok_next  = 1'b0;
            sec_ok_next   = 1'b0;
        end
        else if (cmd.scan_run)
        begin
            if (scan_idx_reg < limit)
            begin
                pend_next     = 1'b1;
                rd_idx_next   = scan_idx_reg;
                scan_idx_next = scan_idx_reg + NW'(1);
            end
            else
            begin
                pend_next = 1'b0;
            end
            if (pend_reg)
            begin
                if (cmd.scan_min)
                begin
                    if (active_reg[rd_idx_reg])
                    begin
                        if (!best_ok_reg || (wt_rdata < best_w_reg))
                        begin
                            sec_ok_next  = best_ok_reg;
                            sec_w_next   = best_w_reg;
                            sec_i_next   = best_i_reg;
                            best_ok_next = 1'b1;
                            best_w_next  = wt_rdata;
                            best_i_next  = rd_idx_reg;
                        end
                        else if (!sec_ok_reg || (wt_rdata < sec_w_reg))
                        begin
                            sec_ok_next = 1'b1;
                            sec_w_next  = wt_rdata;
                            sec_i_next  = rd_idx_reg;
                        end
                    end
                end
                else if (leaf_rdata == sym_reg)
                begin
                    found_next = 1'b1;
                    fidx_next  = rd_idx_reg[LW-1:0];
                end
            end
        end

        if (cmd.load_wr && (found_reg || leaf_we))
        begin
            ready_next = 1'b0;
            if (leaf_we)
            begin
                cnt_next = cnt_reg + CW'(1);
            end
        end

        if (cmd.build_init)
        begin
            for (int i = 0; i < NSLOT; i++)
            begin
                active_next[i] = (i < int'(cnt_reg));
            end
            next_next = NW'(cnt_reg);
        end

        if (cmd.merge)
        begin
            active_next[best_i_reg] = 1'b0;
            active_next[sec_i_reg]  = 1'b0;
            active_next[next_reg]   = 1'b1;
            next_next               = next_reg + NW'(1);
        end

        if (cmd.root_init)
        begin
            p_next = next_reg - NW'(1);
        end

        if (cmd.walk_c1)
        begin
            p_next = p_reg - NW'(1);
        end

        if (cmd.set_ready)
        begin
            ready_next = 1'b1;
        end

        if (cmd.q_cap)
        begin
            qbits_next = path_rdata[PW-1:hcb_pkg::LEN_W];
            qlen_next  = path_rdata[hcb_pkg::LEN_W-1:0];
        end

        if (cmd.fin)
        begin
            rsp_valid_next        = 1'b1;
            rsp_next.status       = cmd.status;
            rsp_next.code_bits    = qbits_reg;
            rsp_next.code_length  = qlen_reg;
            rsp_next.symbol_count = hcb_pkg::COUNT_W'(cnt_reg);
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            ready_reg     <= 1'b0;
            active_reg    <= '0;
            scan_idx_reg  <= '0;
            pend_reg      <= 1'b0;
            found_reg     <= 1'b0;
            best_ok_reg   <= 1'b0;
            sec_ok_reg    <= 1'b0;
            next_reg      <= '0;
            p_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            ready_reg     <= ready_next;
            active_reg    <= active_next;
            scan_idx_reg  <= scan_idx_next;
            pend_reg      <= pend_next;
            found_reg     <= found_next;
            best_ok_reg   <= best_ok_next;
            sec_ok_reg    <= sec_ok_next;
            next_reg      <= next_next;
            p_reg         <= p_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg    <= sym_next;
        freq_reg   <= freq_next;
        rd_idx_reg <= rd_idx_next;
        fidx_reg   <= fidx_next;
        best_w_reg <= best_w_next;
        best_i_reg <= best_i_next;
        sec_w_reg  <= sec_w_next;
        sec_i_reg  <= sec_i_next;
        qbits_reg  <= qbits_next;
        qlen_reg   <= qlen_next;
        rsp_reg    <= rsp_next;
    end

    assign stat.scan_done  = (scan_idx_reg >= limit) && !pend_reg;
    assign stat.found      = found_reg;
    assign stat.full       = (cnt_reg == CW'(MAX_SYMBOLS));
    assign stat.cnt_zero   = (cnt_reg == '0);
    assign stat.lone       = (cnt_reg == CW'(1));
    assign stat.merge_last = ((NW + 1)'(next_reg) + (NW + 1)'(1))
                             == ((NW + 1)'({cnt_reg, 1'b0}) - (NW + 1)'(1));
    assign stat.walk_last  = (p_reg == NW'(cnt_reg));
    assign stat.ready      = ready_reg;
    assign stat.rsp_free   = !rsp_valid_reg || !rsp_stall;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hdl/huffman_code_builder.sv -----
// Top level of the Huffman code builder: sequencer, datapath and assertions.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-----------------------------
//   request | req_valid | req_stall | req (kind, symbol, frequency)
//   result  | rsp_valid | rsp_stall | rsp (status, code, length, count)
//
// One request at a time; req_stall is low only while the sequencer is idle.
// Load and query time grows with the number of loaded symbols, set by the
// one-entry-per-cycle scan of the symbol memory; clear and empty build do not scan.
// Build time is set by the minimum scan over the weight memory before each merge
// and by the code walk, which visits each parent node in turn.
// Reset clears counters and active flags at once; no clearing pass is needed.
// A held result does not block acceptance of the next request; a stalled result
// only delays the following one at its final step.
module huffman_code_builder #(
    parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
    parameter int FREQ_WIDTH  = hcb_pkg::FREQ_WIDTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  hcb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output hcb_pkg::rsp_t rsp
);

    hcb_pkg::cmd_t  cmd;
    hcb_pkg::stat_t stat;

    // sequencer: one state per step of the load, query and build flows
    hcb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_kind  (req.kind),
        .req_stall (req_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    // memories, scan unit, merge adder and result register
    hcb_dpath #(
        .MAX_SYMBOLS (MAX_SYMBOLS),
        .FREQ_WIDTH  (FREQ_WIDTH)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

`ifndef SYNTHESIS
    // a finished request frees the request side on the next cycle
    a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.fin |=> !req_stall)
        else $error("sequencer not idle after result");

    // only successful queries carry a code
    a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp.status != hcb_pkg::ST_OK)) |->
        ((rsp.code_bits == '0) && (rsp.code_length == '0)))
        else $error("code present on failed request");

    // the symbol count never passes the table size
    a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.symbol_count <= hcb_pkg::COUNT_W'(MAX_SYMBOLS)))
        else $error("symbol count beyond table size");
`endif

endmodule
